@@ rtl/adab_pkg.sv @@
// AdaBelief update engine: shared constants, types and saturation helpers.
// Used by every module of the block but the RAM; depends on nothing else.
`timescale 1ns / 1ps

package adab_pkg;

    localparam int MAX_PARAMS = 1024;
    localparam int IDX_W      = $clog2(MAX_PARAMS);
    localparam int LEN_W      = 11;
    localparam int FRAC_BITS  = 24;
    localparam int DATA_W     = 32;
    localparam int COEF_W     = 24;
    localparam int POW_W      = FRAC_BITS + 1;
    localparam int MEM_W      = 3 * DATA_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int ROOT_W     = (DATA_W + FRAC_BITS) / 2;
    localparam int SQX_W      = 2 * ROOT_W;

    localparam logic [POW_W-1:0] ONE_Q = POW_W'(1) << FRAC_BITS;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_FIRST     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_BELIEF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STABILITY_TERM = 3'd4;

    localparam logic [LEN_W-1:0]  RST_VECTOR_LENGTH  = 11'd1024;
    localparam logic [COEF_W-1:0] RST_BETA_FIRST     = 24'd15099494;
    localparam logic [COEF_W-1:0] RST_BETA_BELIEF    = 24'd16760439;
    localparam logic [COEF_W-1:0] RST_LEARNING_RATE  = 24'd1678;
    localparam logic [COEF_W-1:0] RST_STABILITY_TERM = 24'd1;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [COEF_W-1:0] beta_first;
        logic [COEF_W-1:0] beta_belief;
        logic [COEF_W-1:0] learning_rate;
        logic [COEF_W-1:0] stability_term;
    } cfg_t;

    // One classified word handed from the front to the back.
    typedef struct packed {
        logic signed [DATA_W-1:0] grad;
        logic [IDX_W-1:0]         idx;
        logic                     last;
        logic                     first;
    } job_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
        if (x > S32_MAX) begin
            return 32'sh7fffffff;
        end else if (x < S32_MIN) begin
            return 32'sh80000000;
        end else begin
            return x[DATA_W-1:0];
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_pos(input logic signed [63:0] x);
        if (x < 64'sd0) begin
            return 32'sd0;
        end else if (x > S32_MAX) begin
            return 32'sh7fffffff;
        end else begin
            return x[DATA_W-1:0];
        end
    endfunction

endpackage

@@ rtl/adab_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module adab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/adab_div.sv @@
// Iterative restoring divider, one quotient bit per cycle, signed saturated result.
// Depends on adab_pkg for widths and limits.
`timescale 1ns / 1ps

module adab_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [63:0]                      dividend,
    input  logic [adab_pkg::DATA_W-1:0]      divisor,
    input  logic                             negate,
    output logic                             done,
    output logic signed [adab_pkg::DATA_W-1:0] quotient
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [4:0]                      cnt_reg;
    logic [adab_pkg::DATA_W-1:0]     rem_reg;
    logic [adab_pkg::DATA_W-1:0]     low_reg;
    logic [adab_pkg::DATA_W-1:0]     q_reg;
    logic [adab_pkg::DATA_W-1:0]     dvsr_reg;
    logic                            neg_reg;
    logic                            ovf_reg;

    logic [adab_pkg::DATA_W:0]       trial;
    logic                            fits;
    logic [adab_pkg::DATA_W-1:0]     rem_next;

    assign trial    = {rem_reg, low_reg[adab_pkg::DATA_W-1]};
    assign fits     = trial >= {1'b0, dvsr_reg};
    assign rem_next = fits ? adab_pkg::DATA_W'(trial - {1'b0, dvsr_reg})
                           : trial[adab_pkg::DATA_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= dividend[63:32];
                low_reg  <= dividend[31:0];
                q_reg    <= '0;
                dvsr_reg <= divisor;
                neg_reg  <= negate;
                // A high half at or above the divisor means the quotient needs
                // more than 32 bits, so it saturates whatever the low bits are.
                ovf_reg  <= dividend[63:32] >= divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                low_reg <= {low_reg[adab_pkg::DATA_W-2:0], 1'b0};
                q_reg   <= {q_reg[adab_pkg::DATA_W-2:0], fits};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (ovf_reg) begin
            quotient = neg_reg ? 32'sh80000000 : 32'sh7fffffff;
        end else if (neg_reg) begin
            quotient = (q_reg > 32'h80000000) ? 32'sh80000000 : -$signed(q_reg);
        end else begin
            quotient = (q_reg > 32'h7fffffff) ? 32'sh7fffffff : $signed(q_reg);
        end
    end

    assign done = done_reg;

endmodule

@@ rtl/adab_fifo.sv @@
// Two-word queue between the front and the back of the update engine.
// Depends on adab_pkg for the word type.
`timescale 1ns / 1ps

module adab_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  adab_pkg::job_t   push_data,
    output logic             full,
    input  logic             pop,
    output adab_pkg::job_t   pop_data,
    output logic             empty
);

    adab_pkg::job_t slot_reg [2];
    logic           wptr_reg;
    logic           rptr_reg;
    logic [1:0]     count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                slot_reg[wptr_reg] <= push_data;
                wptr_reg           <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assign pop_data = slot_reg[rptr_reg];
    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;

endmodule

@@ rtl/adab_front.sv @@
// Front of the update engine: configuration registers, input acceptance,
// vector position tracking. Depends on adab_pkg.
`timescale 1ns / 1ps

module adab_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [adab_pkg::DATA_W-1:0]       s_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [adab_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [adab_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              clear_done,
    input  logic                              fifo_full,
    output logic                              push,
    output adab_pkg::job_t                    push_data,
    output adab_pkg::cfg_t                    cfg
);

    logic [adab_pkg::LEN_W-1:0]  vlen_reg;
    adab_pkg::cfg_t              cfg_reg;
    logic [adab_pkg::IDX_W-1:0]  pos_reg;
    logic [adab_pkg::LEN_W-1:0]  len_eff;
    logic                        last;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vlen_reg               <= adab_pkg::RST_VECTOR_LENGTH;
            cfg_reg.beta_first     <= adab_pkg::RST_BETA_FIRST;
            cfg_reg.beta_belief    <= adab_pkg::RST_BETA_BELIEF;
            cfg_reg.learning_rate  <= adab_pkg::RST_LEARNING_RATE;
            cfg_reg.stability_term <= adab_pkg::RST_STABILITY_TERM;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                adab_pkg::REG_VECTOR_LENGTH:
                    vlen_reg <= cfg_data[adab_pkg::LEN_W-1:0];
                adab_pkg::REG_BETA_FIRST:     cfg_reg.beta_first     <= cfg_data;
                adab_pkg::REG_BETA_BELIEF:    cfg_reg.beta_belief    <= cfg_data;
                adab_pkg::REG_LEARNING_RATE:  cfg_reg.learning_rate  <= cfg_data;
                adab_pkg::REG_STABILITY_TERM: cfg_reg.stability_term <= cfg_data;
                default: ;
            endcase
        end
    end

    // A length of zero runs as one, anything above the store depth as the depth.
    always_comb begin
        if (vlen_reg == '0) begin
            len_eff = adab_pkg::LEN_W'(1);
        end else if (vlen_reg > adab_pkg::LEN_W'(adab_pkg::MAX_PARAMS)) begin
            len_eff = adab_pkg::LEN_W'(adab_pkg::MAX_PARAMS);
        end else begin
            len_eff = vlen_reg;
        end
    end

    assign last     = ({1'b0, pos_reg} + adab_pkg::LEN_W'(1)) >= len_eff;
    assign s_tready = clear_done && !fifo_full;
    assign push     = s_tvalid && s_tready;

    assign push_data.grad  = $signed(s_tdata);
    assign push_data.idx   = pos_reg;
    assign push_data.last  = last;
    assign push_data.first = pos_reg == '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (push) begin
            pos_reg <= last ? '0 : pos_reg + adab_pkg::IDX_W'(1);
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/adab_back.sv @@
// Back of the update engine: moment and parameter stores, multiply sequence,
// bit-serial square root, shared divider and the output register.
// Depends on adab_pkg, adab_ram and adab_div.
`timescale 1ns / 1ps

module adab_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  adab_pkg::cfg_t                 cfg,
    input  logic                           job_empty,
    input  adab_pkg::job_t                 job_in,
    output logic                           pop,
    output logic                           clear_done,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [47:0]                    m_tdata,
    output logic                           m_tlast
);

    typedef enum logic [19:0] {
        ST_CLR   = 20'h00001,
        ST_IDLE  = 20'h00002,
        ST_POW   = 20'h00004,
        ST_CORF  = 20'h00008,
        ST_CORFW = 20'h00010,
        ST_CORB  = 20'h00020,
        ST_CORBW = 20'h00040,
        ST_M1    = 20'h00080,
        ST_M2    = 20'h00100,
        ST_M3    = 20'h00200,
        ST_M4    = 20'h00400,
        ST_M5    = 20'h00800,
        ST_M6    = 20'h01000,
        ST_M7    = 20'h02000,
        ST_M8    = 20'h04000,
        ST_SQRT  = 20'h08000,
        ST_DIVS  = 20'h10000,
        ST_DIVW  = 20'h20000,
        ST_WR    = 20'h40000,
        ST_HOLD  = 20'h80000
    } state_t;

    localparam int FB = adab_pkg::FRAC_BITS;
    localparam int DW = adab_pkg::DATA_W;
    localparam int PW = adab_pkg::POW_W;
    localparam int RW = adab_pkg::ROOT_W;
    localparam int XW = adab_pkg::SQX_W;
    localparam logic [63:0] CORR_NUM = 64'd1 << (2 * FB);

    state_t state_reg, state_next;

    logic [adab_pkg::IDX_W-1:0] clr_cnt_reg;
    adab_pkg::job_t             job_reg;
    logic [PW-1:0]              pow_f_reg, pow_b_reg;
    logic signed [DW-1:0]       corr_f_reg, corr_b_reg;
    logic signed [63:0]         prod_a_reg, prod_b_reg;
    logic signed [63:0]         sq_prod_reg, mh_prod_reg, sh_prod_reg, lr_prod_reg;
    logic signed [DW-1:0]       m_reg, s_reg, mhat_reg, upd_reg;
    logic [DW-2:0]              sqc_reg;
    logic [XW-1:0]              sq_x_reg;
    logic [RW+1:0]              sq_rem_reg;
    logic [RW-1:0]              sq_root_reg;
    logic [4:0]                 sq_cnt_reg;
    logic                       out_valid_reg;
    logic signed [DW-1:0]       out_value_reg;
    logic [adab_pkg::IDX_W-1:0] out_index_reg;
    logic                       out_last_reg;

    logic                          mem_we, mem_re;
    logic [adab_pkg::IDX_W-1:0]    mem_waddr;
    logic [adab_pkg::MEM_W-1:0]    mem_wdata, mem_rdata;
    logic signed [DW-1:0]          m_old, s_old, p_old;

    logic                          div_start, div_negate, div_done;
    logic [63:0]                   div_dividend;
    logic [DW-1:0]                 div_divisor;
    logic signed [DW-1:0]          div_q;

    logic [2*PW-2:0]               pf_prod, pb_prod;
    logic [PW-1:0]                 omb1, omb2;
    logic signed [DW-1:0]          diff, shat, new_value;
    logic signed [63:0]            sq_scaled;
    logic signed [PW:0]            den_f, den_b;
    logic [PW:0]                   mag_f, mag_b;
    logic [RW+3:0]                 sq_rem2, sq_trial;
    logic                          sq_fits;
    logic [DW-1:0]                 denom;

    adab_ram #(
        .WIDTH (adab_pkg::MEM_W),
        .DEPTH (adab_pkg::MAX_PARAMS)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (job_in.idx),
        .rdata (mem_rdata)
    );

    adab_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .negate   (div_negate),
        .done     (div_done),
        .quotient (div_q)
    );

    // Store word: first moment on top, belief moment, then the parameter.
    assign m_old = $signed(mem_rdata[3*DW-1:2*DW]);
    assign s_old = $signed(mem_rdata[2*DW-1:DW]);
    assign p_old = $signed(mem_rdata[DW-1:0]);

    assign pf_prod = {{(PW-1){1'b0}}, pow_f_reg} * {{PW{1'b0}}, cfg.beta_first[PW-2:0]};
    assign pb_prod = {{(PW-1){1'b0}}, pow_b_reg} * {{PW{1'b0}}, cfg.beta_belief[PW-2:0]};
    assign omb1    = adab_pkg::ONE_Q - {1'b0, cfg.beta_first};
    assign omb2    = adab_pkg::ONE_Q - {1'b0, cfg.beta_belief};

    assign den_f = $signed({1'b0, adab_pkg::ONE_Q}) - $signed({1'b0, pow_f_reg});
    assign den_b = $signed({1'b0, adab_pkg::ONE_Q}) - $signed({1'b0, pow_b_reg});
    assign mag_f = den_f[PW] ? unsigned'(-den_f) : unsigned'(den_f);
    assign mag_b = den_b[PW] ? unsigned'(-den_b) : unsigned'(den_b);

    assign diff      = adab_pkg::sat32(64'(job_reg.grad) + 64'(m_reg));
    assign sq_scaled = sq_prod_reg >>> FB;
    assign shat      = adab_pkg::clamp_pos(sh_prod_reg >>> FB);
    assign new_value = adab_pkg::sat32(64'(p_old) - 64'(upd_reg));

    // Digit-by-digit floor root, two radicand bits per step.
    assign sq_rem2  = {sq_rem_reg, sq_x_reg[XW-1:XW-2]};
    assign sq_trial = {2'b00, sq_root_reg, 2'b01};
    assign sq_fits  = sq_rem2 >= sq_trial;

    assign denom = DW'(sq_root_reg) + DW'(cfg.stability_term);

    always_comb begin
        state_next   = state_reg;
        pop          = 1'b0;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = job_reg.idx;
        mem_wdata    = {m_reg, s_reg, new_value};
        div_start    = 1'b0;
        div_dividend = CORR_NUM;
        div_divisor  = DW'(mag_f);
        div_negate   = den_f[PW];
        unique case (state_reg)
            ST_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == adab_pkg::IDX_W'(adab_pkg::MAX_PARAMS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!job_empty) begin
                    pop        = 1'b1;
                    mem_re     = 1'b1;
                    state_next = job_in.first ? ST_POW : ST_M1;
                end
            end
            ST_POW: state_next = ST_CORF;
            ST_CORF: begin
                div_start  = 1'b1;
                state_next = ST_CORFW;
            end
            ST_CORFW: begin
                if (div_done) begin
                    state_next = ST_CORB;
                end
            end
            ST_CORB: begin
                div_start   = 1'b1;
                div_divisor = DW'(mag_b);
                div_negate  = den_b[PW];
                state_next  = ST_CORBW;
            end
            ST_CORBW: begin
                if (div_done) begin
                    state_next = ST_M1;
                end
            end
            ST_M1: state_next = ST_M2;
            ST_M2: state_next = ST_M3;
            ST_M3: state_next = ST_M4;
            ST_M4: state_next = ST_M5;
            ST_M5: state_next = ST_M6;
            ST_M6: state_next = ST_M7;
            ST_M7: state_next = ST_M8;
            ST_M8: state_next = ST_SQRT;
            ST_SQRT: begin
                if (sq_cnt_reg == 5'(RW - 1)) begin
                    state_next = ST_DIVS;
                end
            end
            ST_DIVS: begin
                div_dividend = lr_prod_reg[63] ? unsigned'(-lr_prod_reg)
                                               : unsigned'(lr_prod_reg);
                div_divisor  = denom;
                div_negate   = lr_prod_reg[63];
                if (denom == '0) begin
                    state_next = ST_WR;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIVW;
                end
            end
            ST_DIVW: begin
                if (div_done) begin
                    state_next = ST_WR;
                end
            end
            ST_WR: state_next = ST_HOLD;
            ST_HOLD: begin
                // The read word stays on the RAM output until the next read.
                if (!out_valid_reg || m_tready) begin
                    mem_we     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            pow_f_reg     <= adab_pkg::ONE_Q;
            pow_b_reg     <= adab_pkg::ONE_Q;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLR) begin
                clr_cnt_reg <= clr_cnt_reg + adab_pkg::IDX_W'(1);
            end
            if (state_reg == ST_POW) begin
                pow_f_reg <= pf_prod[FB+PW-1:FB];
                pow_b_reg <= pb_prod[FB+PW-1:FB];
            end
            if (state_reg == ST_HOLD && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
                out_value_reg <= new_value;
                out_index_reg <= job_reg.idx;
                out_last_reg  <= job_reg.last;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (!job_empty) begin
                    job_reg <= job_in;
                end
            end
            ST_CORFW: begin
                if (div_done) begin
                    corr_f_reg <= div_q;
                end
            end
            ST_CORBW: begin
                if (div_done) begin
                    corr_b_reg <= div_q;
                end
            end
            ST_M1: begin
                prod_a_reg <= $signed({1'b0, cfg.beta_first}) * m_old;
                prod_b_reg <= $signed({1'b0, omb1}) * job_reg.grad;
            end
            ST_M2: m_reg <= adab_pkg::sat32((prod_a_reg - prod_b_reg) >>> FB);
            ST_M3: begin
                sq_prod_reg <= 64'(diff) * 64'(diff);
                mh_prod_reg <= 64'(m_reg) * 64'(corr_f_reg);
            end
            ST_M4: begin
                sqc_reg  <= (sq_scaled > adab_pkg::S32_MAX) ? {(DW-1){1'b1}}
                                                            : sq_scaled[DW-2:0];
                mhat_reg <= adab_pkg::sat32(mh_prod_reg >>> FB);
            end
            ST_M5: begin
                prod_a_reg <= $signed({1'b0, cfg.beta_belief}) * s_old;
                prod_b_reg <= $signed({1'b0, omb2}) * $signed({1'b0, sqc_reg});
            end
            ST_M6: s_reg <= adab_pkg::clamp_pos((prod_a_reg + prod_b_reg) >>> FB);
            ST_M7: sh_prod_reg <= 64'(s_reg) * 64'(corr_b_reg);
            ST_M8: begin
                sq_x_reg    <= XW'({shat[DW-2:0], {FB{1'b0}}});
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
                sq_cnt_reg  <= '0;
                lr_prod_reg <= $signed({1'b0, cfg.learning_rate}) * mhat_reg;
            end
            ST_SQRT: begin
                sq_x_reg    <= {sq_x_reg[XW-3:0], 2'b00};
                sq_rem_reg  <= sq_fits ? (RW+2)'(sq_rem2 - sq_trial) : sq_rem2[RW+1:0];
                sq_root_reg <= {sq_root_reg[RW-2:0], sq_fits};
                sq_cnt_reg  <= sq_cnt_reg + 5'd1;
            end
            ST_DIVS: begin
                // Zero denominator: full-scale step with the sign of mhat, zero when mhat is zero.
                if (denom == '0) begin
                    if (mhat_reg > 32'sd0) begin
                        upd_reg <= 32'sh7fffffff;
                    end else if (mhat_reg < 32'sd0) begin
                        upd_reg <= 32'sh80000000;
                    end else begin
                        upd_reg <= 32'sd0;
                    end
                end
            end
            ST_DIVW: begin
                if (div_done) begin
                    upd_reg <= div_q;
                end
            end
            default: ;
        endcase
    end

    assign clear_done = state_reg != ST_CLR;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {6'b0, out_index_reg, out_value_reg};
    assign m_tlast    = out_last_reg;

endmodule

@@ rtl/adabelief_parameter_update.sv @@
// Top level of the AdaBelief parameter update engine.
// Depends on adab_pkg, adab_front, adab_fifo and adab_back.
//
//  Port group    Dir  Payload
//  s_*           in   tdata[31:0] grad_element
//  m_*           out  tdata[31:0] updated_value, [41:32] element_index; tlast step_done
//  cfg_*         in   cfg_index register number, cfg_data register value
//
// Each element passes the back end alone; its time is set by the 28-step square
// root and the divider wait (skipped when the denominator is zero); the first
// element of a step also waits for the beta powers and the two corrections.
// After reset a clearing pass zeroes all 1024 store entries; no word is taken
// meanwhile. A two-word queue lets the input side run ahead while results stall.
`timescale 1ns / 1ps

module adabelief_parameter_update (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // [31:0] grad_element
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [47:0]                       m_tdata,   // [31:0] updated_value,
                                                         // [41:32] element_index
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [adab_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [adab_pkg::CFG_DATA_W-1:0]   cfg_data
);

    adab_pkg::cfg_t cfg;
    adab_pkg::job_t push_data, pop_data;
    logic           push, pop, fifo_full, fifo_empty, clear_done;

    adab_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .clear_done (clear_done),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_data  (push_data),
        .cfg        (cfg)
    );

    adab_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (fifo_empty)
    );

    adab_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .job_empty  (fifo_empty),
        .job_in     (pop_data),
        .pop        (pop),
        .clear_done (clear_done),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

@@ verif/adabelief_parameter_update_test.sv @@
// Self-checking test of the AdaBelief parameter update engine.
// Depends on adab_pkg and the adabelief_parameter_update RTL; predicts each word in a class.
`timescale 1ns / 1ps

class adab_scoreboard;
    logic signed [63:0] first_mom [1024];
    logic signed [63:0] belief_mom [1024];
    logic signed [63:0] param_val [1024];
    logic [63:0] pow_first, pow_belief;
    logic signed [63:0] corr_first, corr_belief;
    int unsigned position;
    logic [10:0] len_reg;
    logic [23:0] b1_reg, b2_reg, eta_reg, eps_reg;
    logic [31:0] exp_value[$];
    logic [9:0]  exp_index[$];
    logic        exp_done[$];
    int errors;
    int checked;

    function new();
        for (int i = 0; i < 1024; i++) begin
            first_mom[i] = 0; belief_mom[i] = 0; param_val[i] = 0;
        end
        pow_first = 64'd1 << 24; pow_belief = 64'd1 << 24;
        corr_first = 0; corr_belief = 0; position = 0;
        len_reg = 11'd1024; b1_reg = 24'd15099494; b2_reg = 24'd16760439;
        eta_reg = 24'd1678; eps_reg = 24'd1;
        errors = 0; checked = 0;
    endfunction

    function logic signed [63:0] sat(logic signed [63:0] x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function logic signed [63:0] clip_pos(logic signed [63:0] x);
        if (x < 0) return 0;
        if (x > 64'sd2147483647) return 64'sd2147483647;
        return x;
    endfunction

    // Arithmetic shift is a floor division by 2^24.
    function logic signed [63:0] floor_scale(logic signed [63:0] x);
        return x >>> 24;
    endfunction

    function logic [63:0] floor_root(logic [63:0] x);
        logic [63:0] r, b;
        r = 0; b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b); r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function logic [63:0] advance_power(logic [63:0] p, logic [23:0] beta);
        logic [63:0] q;
        q = (p * beta) >> 24;
        return (q > 64'h1FFFFFF) ? 64'h1FFFFFF : q;
    endfunction

    function logic signed [63:0] bias_factor(logic [63:0] p);
        logic signed [63:0] d;
        d = (64'sd1 <<< 24) - $signed(p);
        if (d == 0) return 64'sd2147483647;
        return sat((64'sd1 <<< 48) / d);
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
        case (idx)
            adab_pkg::REG_VECTOR_LENGTH:  len_reg = val[10:0];
            adab_pkg::REG_BETA_FIRST:     b1_reg = val;
            adab_pkg::REG_BETA_BELIEF:    b2_reg = val;
            adab_pkg::REG_LEARNING_RATE:  eta_reg = val;
            adab_pkg::REG_STABILITY_TERM: eps_reg = val;
            default: ;
        endcase
    endfunction

    function void note_grad(logic [31:0] word);
        int unsigned len, idx;
        logic signed [63:0] g, b1, b2, m, s, diff, sq, mhat, shat, upd, newp, one;
        logic [63:0] sqr, denom;
        logic done;
        one = 64'sd1 <<< 24;
        len = len_reg; idx = position;
        if (len == 0) len = 1;
        if (len > 1024) len = 1024;
        if (idx >= 1024) idx = 0;
        if (idx == 0) begin
            pow_first = advance_power(pow_first, b1_reg);
            pow_belief = advance_power(pow_belief, b2_reg);
            corr_first = bias_factor(pow_first);
            corr_belief = bias_factor(pow_belief);
        end
        g = $signed(word);
        b1 = b1_reg; b2 = b2_reg;
        m = sat(floor_scale(b1 * first_mom[idx] - (one - b1) * g));
        first_mom[idx] = m;
        diff = sat(g + m);
        sqr = $unsigned(diff * diff) >> 24;
        sq = (sqr > 64'd2147483647) ? 64'sd2147483647 : $signed(sqr);
        s = clip_pos(floor_scale(b2 * belief_mom[idx] + (one - b2) * sq));
        belief_mom[idx] = s;
        mhat = sat(floor_scale(m * corr_first));
        shat = clip_pos(floor_scale(s * corr_belief));
        denom = floor_root($unsigned(shat) << 24) + eps_reg;
        if (denom == 0) begin
            upd = (mhat > 0) ? 64'sd2147483647 : ((mhat < 0) ? -64'sd2147483648 : 0);
        end else begin
            upd = sat(($signed({40'd0, eta_reg}) * mhat) / $signed(denom));
        end
        newp = sat(param_val[idx] - upd);
        param_val[idx] = newp;
        done = (idx + 1 >= len);
        position = done ? 0 : idx + 1;
        exp_value.push_back(newp[31:0]);
        exp_index.push_back(idx[9:0]);
        exp_done.push_back(done);
    endfunction

    task report(string what);
        errors++;
        $display("error at %0t: %s", $time, what);
    endtask

    task check_word(logic [47:0] data, logic last);
        logic [31:0] v; logic [9:0] i; logic d;
        checked++;
        if (exp_value.size() == 0) begin
            report("result word with nothing expected");
            return;
        end
        v = exp_value.pop_front(); i = exp_index.pop_front(); d = exp_done.pop_front();
        if (data[31:0] !== v)
            report($sformatf("value got %h want %h", data[31:0], v));
        if (data[41:32] !== i)
            report($sformatf("index got %0d want %0d", data[41:32], i));
        if (last !== d)
            report($sformatf("step_done got %b want %b", last, d));
    endtask
endclass

module adabelief_parameter_update_test;
    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [31:0] s_tdata = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [47:0] m_tdata;
    logic m_tlast;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [2:0] cfg_index = 0;
    logic [23:0] cfg_data = 0;
    logic stim_done = 0;
    longint cycles = 0;
    adab_scoreboard sb;

    adabelief_parameter_update u_dut (.*);

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd2500000) begin
            $display("timeout");
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random stalls, checks taken at the rising edge.
    initial begin
        int w;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            w = $urandom_range(0, 6);
            m_tready = 0;
            repeat (w) @(negedge aclk);
            m_tready = 1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_word(m_tdata, m_tlast);
        end
    end

    task send_grad(logic [31:0] g);
        int w;
        w = $urandom_range(0, 6);
        repeat (w) @(negedge aclk);
        s_tvalid = 1; s_tdata = g;
        do @(posedge aclk); while (!s_tready);
        sb.note_grad(g);
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    task write_cfg(logic [2:0] idx, logic [23:0] val);
        cfg_valid = 1; cfg_index = idx; cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    task wait_idle();
        while (sb.exp_value.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    function logic [31:0] rand_grad();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'h80000000 | ($urandom() & 32'h1);
            2: return $urandom() & 32'h01FFFFFF;
            3: return -($urandom() & 32'h01FFFFFF);
            default: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h00000000;
        endcase
    endfunction

    task set_all(logic [10:0] len, logic [23:0] b1, logic [23:0] b2,
                 logic [23:0] eta, logic [23:0] eps);
        write_cfg(adab_pkg::REG_VECTOR_LENGTH, {13'd0, len});
        write_cfg(adab_pkg::REG_BETA_FIRST, b1);
        write_cfg(adab_pkg::REG_BETA_BELIEF, b2);
        write_cfg(adab_pkg::REG_LEARNING_RATE, eta);
        write_cfg(adab_pkg::REG_STABILITY_TERM, eps);
    endtask

    initial begin
        int n;
        sb = new();
        repeat (12) @(negedge aclk);
        aresetn = 1;
        // Directed: short steps, extreme gradients, zero epsilon with zero belief.
        set_all(11'd4, 24'd15099494, 24'd16760439, 24'd1678, 24'd1);
        send_grad(32'h7FFFFFFF); send_grad(32'h80000000);
        send_grad(32'h00000000); send_grad(32'hFFFFFFFF);
        send_grad(32'h01000000); send_grad(32'hFF000000);
        send_grad(32'h00000001); send_grad(32'h55555555);
        wait_idle();
        set_all(11'd0, 24'd0, 24'd0, 24'hFFFFFF, 24'd0);
        send_grad(32'h00000000); send_grad(32'hAAAAAAAA); send_grad(32'h7FFFFFFF);
        wait_idle();
        set_all(11'd2047, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_grad(32'h12345678); send_grad(32'hEDCBA987); send_grad(32'h80000000);
        wait_idle();
        // Lowering the length in the middle of a step ends it early.
        write_cfg(adab_pkg::REG_VECTOR_LENGTH, 24'd2);
        send_grad(32'h00800000); send_grad(32'hFF800000);
        wait_idle();
        // Random phases with mostly small vectors.
        for (int ph = 0; ph < 10; ph++) begin
            set_all(ph == 9 ? 11'd1024 : 11'($urandom_range(1, 24)),
                    ph % 3 == 0 ? 24'hFFFFFF : 24'($urandom()),
                    ph % 4 == 1 ? 24'd0 : 24'($urandom()),
                    24'($urandom()), ph % 5 == 2 ? 24'd0 : 24'($urandom_range(0, 4096)));
            n = (ph == 9) ? 200 : 100;
            for (int k = 0; k < n; k++) send_grad(rand_grad());
            wait_idle();
        end
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        $display("Ran %0d result words over directed extremes and ten random settings.",
                 sb.checked);
        if (sb.errors == 0 && sb.exp_value.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
